### hw/rtl/ppdc_pkg.sv
// Shared types and constants of the pulse period and duty checker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ppdc_pkg;

  // Defaults of the top level parameters
  localparam int unsigned PERIODS_DEF    = 4;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned PBOUND_W   = 16;
  localparam int unsigned DBOUND_W   = 17;

  // Payload widths of the result beat
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned PIDX_W  = 2;

  // Register reset values
  localparam logic [PBOUND_W-1:0] PERIOD_HIGH_A_RST = 16'd99;
  localparam logic [PBOUND_W-1:0] PERIOD_LOW_A_RST  = 16'd66;
  localparam logic [PBOUND_W-1:0] PERIOD_HIGH_B_RST = 16'd24;
  localparam logic [PBOUND_W-1:0] PERIOD_LOW_B_RST  = 16'd16;
  localparam logic [DBOUND_W-1:0] DUTY_HIGH_A_RST   = 17'd72037;
  localparam logic [DBOUND_W-1:0] DUTY_LOW_A_RST    = 17'd48025;
  localparam logic [DBOUND_W-1:0] DUTY_HIGH_B_RST   = 17'd51590;
  localparam logic [DBOUND_W-1:0] DUTY_LOW_B_RST    = 17'd34393;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_HIGH_A = 3'd0,
    REG_PERIOD_LOW_A  = 3'd1,
    REG_PERIOD_HIGH_B = 3'd2,
    REG_PERIOD_LOW_B  = 3'd3,
    REG_DUTY_HIGH_A   = 3'd4,
    REG_DUTY_LOW_A    = 3'd5,
    REG_DUTY_HIGH_B   = 3'd6,
    REG_DUTY_LOW_B    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_FAIL     = 2'd1,
    VERDICT_PASS     = 2'd2
  } verdict_e;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic kind;
    logic level;
  } in_t;

  typedef struct packed {
    logic                setting;
    logic [PIDX_W-1:0]   period_index;
    logic [TICKS_W-1:0]  period_ticks;
    logic [TICKS_W-1:0]  high_ticks;
    verdict_e            verdict;
  } out_t;

endpackage

`default_nettype wire

### hw/rtl/ppdc_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on ppdc_pkg for the payload structs.
`default_nettype none

interface ppdc_in_if import ppdc_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppdc_out_if import ppdc_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ppdc_judge.sv
// Bound registers and the period/duty pass-fail test of one measured period.
// Depends on ppdc_pkg.
`default_nettype none

module ppdc_judge import ppdc_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  setting_i,
  input  wire logic [COUNT_BITS-1:0] period_i,
  input  wire logic [COUNT_BITS-1:0] high_i,
  output      logic                  fail_o
);

  localparam int unsigned PROD_W = COUNT_BITS + DBOUND_W;

  logic [PBOUND_W-1:0] p_hi_a_q, p_lo_a_q, p_hi_b_q, p_lo_b_q;
  logic [DBOUND_W-1:0] d_hi_a_q, d_lo_a_q, d_hi_b_q, d_lo_b_q;

  logic [PBOUND_W-1:0] p_hi, p_lo;
  logic [DBOUND_W-1:0] d_hi, d_lo;
  logic [PROD_W-1:0]   prod_hi, prod_lo, scaled;
  logic                period_bad, duty_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_hi_a_q <= PERIOD_HIGH_A_RST;
      p_lo_a_q <= PERIOD_LOW_A_RST;
      p_hi_b_q <= PERIOD_HIGH_B_RST;
      p_lo_b_q <= PERIOD_LOW_B_RST;
      d_hi_a_q <= DUTY_HIGH_A_RST;
      d_lo_a_q <= DUTY_LOW_A_RST;
      d_hi_b_q <= DUTY_HIGH_B_RST;
      d_lo_b_q <= DUTY_LOW_B_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PERIOD_HIGH_A: p_hi_a_q <= cfg_data_i[PBOUND_W-1:0];
        REG_PERIOD_LOW_A:  p_lo_a_q <= cfg_data_i[PBOUND_W-1:0];
        REG_PERIOD_HIGH_B: p_hi_b_q <= cfg_data_i[PBOUND_W-1:0];
        REG_PERIOD_LOW_B:  p_lo_b_q <= cfg_data_i[PBOUND_W-1:0];
        REG_DUTY_HIGH_A:   d_hi_a_q <= cfg_data_i;
        REG_DUTY_LOW_A:    d_lo_a_q <= cfg_data_i;
        REG_DUTY_HIGH_B:   d_hi_b_q <= cfg_data_i;
        REG_DUTY_LOW_B:    d_lo_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign p_hi = setting_i ? p_hi_b_q : p_hi_a_q;
  assign p_lo = setting_i ? p_lo_b_q : p_lo_a_q;
  assign d_hi = setting_i ? d_hi_b_q : d_hi_a_q;
  assign d_lo = setting_i ? d_lo_b_q : d_lo_a_q;

  // Exclusive bounds: touching either one fails
  assign period_bad = ({{PBOUND_W{1'b0}}, period_i} >= {{COUNT_BITS{1'b0}}, p_hi})
                   || ({{PBOUND_W{1'b0}}, period_i} <= {{COUNT_BITS{1'b0}}, p_lo});

  // Duty in Q1.16: high * 2^16 against bound * period, exact
  assign prod_hi = PROD_W'(d_hi) * PROD_W'(period_i);
  assign prod_lo = PROD_W'(d_lo) * PROD_W'(period_i);
  assign scaled  = {1'b0, high_i, 16'b0};
  assign duty_bad = (scaled >= prod_hi) || (scaled <= prod_lo);

  assign fail_o = period_bad || duty_bad;

endmodule

`default_nettype wire

### hw/rtl/pulse_period_duty_checker_unit.sv
// Top level of the pulse period and duty checker.
// Depends on ppdc_pkg, ppdc_if (channel interfaces) and ppdc_judge.
`default_nettype none

// The block checks an oscillator from a stream of input beats. A start beat
// (kind 0) resets the check to setting 0; tick beats (kind 1) carry one
// sampled pin level each. In each setting the block waits for a true
// low-to-high transition (a low tick must be seen first), then measures
// PERIODS_PER_SETTING periods, each closed by the next rising tick. Every
// closed period yields one result beat with the setting, the period index,
// the period and high tick counts (saturating at 2^COUNT_BITS-1, low 16 bits
// shown) and a verdict: continue, fail (check stops) or pass (both settings
// done). The setting field doubles as the select pin level. Bounds sit in
// eight registers written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write them only while idle, the block does not enforce it. Rate: one
// input beat per clock unless input ready drops. A beat is held in an input
// register and its result is written to the output register as it leaves.
// The next state, with the two 17 x COUNT_BITS duty products, is worked
// out combinationally. Input ready drops only while the input register holds
// a period-closing tick and the output register is full and stalled.
module pulse_period_duty_checker_unit import ppdc_pkg::*; #(
  parameter int unsigned PERIODS_PER_SETTING = PERIODS_DEF,
  parameter int unsigned COUNT_BITS          = COUNT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  ppdc_in_if.sink                    in_i,
  ppdc_out_if.source                 out_o
);

  localparam int unsigned PC_W = (PERIODS_PER_SETTING > 1) ? $clog2(PERIODS_PER_SETTING) : 1;
  localparam logic [PC_W-1:0]       PC_LAST = PC_W'(PERIODS_PER_SETTING - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  // Input register
  logic in_vld_q;
  in_t  in_q;

  // Check state; period_q tracks the saturated sum of high and low ticks
  phase_e                phase_q, phase_d;
  logic                  setting_q, setting_d;
  logic [PC_W-1:0]       pcnt_q, pcnt_d;
  logic                  prev_q, prev_d;
  logic [COUNT_BITS-1:0] high_q, high_d;
  logic [COUNT_BITS-1:0] period_q, period_d;

  // Output register
  logic out_vld_q;
  out_t out_q;

  logic                  fail;
  logic                  emit;
  logic                  advance;
  verdict_e              verdict;
  logic [COUNT_BITS-1:0] high_inc, period_inc;
  logic [PC_W+1:0]       pidx_ext;
  logic [COUNT_BITS+TICKS_W-1:0] period_ext, high_ext;
  out_t                  res;

  ppdc_judge #(
    .COUNT_BITS (COUNT_BITS)
  ) u_judge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .setting_i  (setting_q),
    .period_i   (period_q),
    .high_i     (high_q),
    .fail_o     (fail)
  );

  assign high_inc   = (high_q == CNT_MAX) ? CNT_MAX : high_q + CNT_ONE;
  assign period_inc = (period_q == CNT_MAX) ? CNT_MAX : period_q + CNT_ONE;

  // A rising tick in the low phase closes a period and makes a result beat
  assign emit = in_vld_q && (in_q.kind == KIND_TICK) && (phase_q == PH_LOW) && in_q.level;
  // Advance unless the result would overwrite a stalled one
  assign advance = in_vld_q && (!emit || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // Next state
  always_comb begin
    phase_d   = phase_q;
    setting_d = setting_q;
    pcnt_d    = pcnt_q;
    prev_d    = prev_q;
    high_d    = high_q;
    period_d  = period_q;
    if (in_q.kind == KIND_START) begin
      phase_d   = PH_WAIT;
      setting_d = 1'b0;
      pcnt_d    = '0;
      prev_d    = 1'b1;
      high_d    = '0;
      period_d  = '0;
    end else begin
      case (phase_q)
        PH_WAIT: begin
          prev_d = in_q.level;
          if (!prev_q && in_q.level) begin
            high_d   = CNT_ONE;
            period_d = CNT_ONE;
            phase_d  = PH_HIGH;
          end
        end
        PH_HIGH: begin
          prev_d   = in_q.level;
          period_d = period_inc;
          if (in_q.level) begin
            high_d = high_inc;
          end else begin
            phase_d = PH_LOW;
          end
        end
        PH_LOW: begin
          prev_d = in_q.level;
          if (!in_q.level) begin
            period_d = period_inc;
          end else if (fail) begin
            phase_d = PH_IDLE;
          end else if (pcnt_q == PC_LAST) begin
            pcnt_d = '0;
            if (!setting_q) begin
              setting_d = 1'b1;
              phase_d   = PH_WAIT;
              prev_d    = 1'b1;
            end else begin
              phase_d = PH_IDLE;
            end
          end else begin
            pcnt_d   = pcnt_q + PC_W'(1);
            high_d   = CNT_ONE;
            period_d = CNT_ONE;
            phase_d  = PH_HIGH;
          end
        end
        default: ;  // idle: ticks are dropped, pin history untouched
      endcase
    end
  end

  // Result payload
  always_comb begin
    if (fail) begin
      verdict = VERDICT_FAIL;
    end else if ((pcnt_q == PC_LAST) && setting_q) begin
      verdict = VERDICT_PASS;
    end else begin
      verdict = VERDICT_CONTINUE;
    end
    pidx_ext   = {2'b00, pcnt_q};
    period_ext = {{TICKS_W{1'b0}}, period_q};
    high_ext   = {{TICKS_W{1'b0}}, high_q};
    res.setting      = setting_q;
    res.period_index = pidx_ext[PIDX_W-1:0];
    res.period_ticks = period_ext[TICKS_W-1:0];
    res.high_ticks   = high_ext[TICKS_W-1:0];
    res.verdict      = verdict;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      setting_q <= 1'b0;
      pcnt_q    <= '0;
      prev_q    <= 1'b1;
      high_q    <= '0;
      period_q  <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      setting_q <= setting_d;
      pcnt_q    <= pcnt_d;
      prev_q    <= prev_d;
      high_q    <= high_d;
      period_q  <= period_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire

### test/ppdc_verdict_tracker.sv
// Result tracker for the pulse period and duty checker: mirrors the bound registers,
// works out every result beat from the accepted input beats and compares.
// Depends on ppdc_pkg and the channel interfaces of ppdc_if.
`default_nettype none

module ppdc_verdict_tracker import ppdc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  ppdc_in_if                         in_mon,
  ppdc_out_if                        out_mon,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  localparam logic [PIDX_W-1:0]  LAST_PERIOD = PIDX_W'(PERIODS_DEF - 1);
  localparam logic [TICKS_W-1:0] TICKS_MAX   = '1;
  localparam logic [TICKS_W-1:0] TICKS_ONE   = TICKS_W'(1);

  logic [DBOUND_W-1:0] bound [8];
  phase_e              meter_phase;
  logic                meter_setting;
  logic [PIDX_W-1:0]   period_num;
  logic                last_level;
  logic [TICKS_W-1:0]  high_run;
  logic [TICKS_W-1:0]  low_run;
  out_t                pending_verdicts [$];
  int unsigned         mismatches;

  function automatic logic [TICKS_W-1:0] bump(input logic [TICKS_W-1:0] v);
    return (v == TICKS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic period_bad(input logic [TICKS_W-1:0] per,
                                      input logic [TICKS_W-1:0] hi);
    logic [DBOUND_W-1:0] p_top;
    logic [DBOUND_W-1:0] p_bot;
    logic [DBOUND_W-1:0] d_top;
    logic [DBOUND_W-1:0] d_bot;
    logic [63:0]         scaled;
    p_top  = meter_setting ? bound[REG_PERIOD_HIGH_B] : bound[REG_PERIOD_HIGH_A];
    p_bot  = meter_setting ? bound[REG_PERIOD_LOW_B]  : bound[REG_PERIOD_LOW_A];
    d_top  = meter_setting ? bound[REG_DUTY_HIGH_B]   : bound[REG_DUTY_HIGH_A];
    d_bot  = meter_setting ? bound[REG_DUTY_LOW_B]    : bound[REG_DUTY_LOW_A];
    scaled = 64'(hi) << 16;
    if (per >= p_top || per <= p_bot) return 1'b1;
    if (scaled >= 64'(d_top) * 64'(per) || scaled <= 64'(d_bot) * 64'(per)) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the meter by one input beat; queue a result when a period closes.
  task automatic advance_meter(input in_t beat);
    logic [TICKS_W:0]   sum;
    logic [TICKS_W-1:0] per;
    out_t               res;
    if (beat.kind == KIND_START) begin
      meter_phase   = PH_WAIT;
      meter_setting = 1'b0;
      period_num    = '0;
      last_level    = 1'b1;
      high_run      = '0;
      low_run       = '0;
    end else begin
      case (meter_phase)
        PH_WAIT: begin
          if (!last_level && beat.level) begin
            high_run    = TICKS_ONE;
            low_run     = '0;
            meter_phase = PH_HIGH;
          end
          last_level = beat.level;
        end
        PH_HIGH: begin
          if (beat.level) begin
            high_run = bump(high_run);
          end else begin
            low_run     = TICKS_ONE;
            meter_phase = PH_LOW;
          end
          last_level = beat.level;
        end
        PH_LOW: begin
          last_level = beat.level;
          if (!beat.level) begin
            low_run = bump(low_run);
          end else begin
            // rising tick closes the period
            sum = {1'b0, high_run} + {1'b0, low_run};
            per = sum[TICKS_W] ? TICKS_MAX : sum[TICKS_W-1:0];
            res.setting      = meter_setting;
            res.period_index = period_num;
            res.period_ticks = per;
            res.high_ticks   = high_run;
            if (period_bad(per, high_run)) begin
              res.verdict = VERDICT_FAIL;
              meter_phase = PH_IDLE;
            end else if (period_num == LAST_PERIOD) begin
              period_num = '0;
              if (!meter_setting) begin
                res.verdict   = VERDICT_CONTINUE;
                meter_setting = 1'b1;
                meter_phase   = PH_WAIT;
                last_level    = 1'b1;
              end else begin
                res.verdict = VERDICT_PASS;
                meter_phase = PH_IDLE;
              end
            end else begin
              period_num  = period_num + 1'b1;
              res.verdict = VERDICT_CONTINUE;
              high_run    = TICKS_ONE;
              low_run     = '0;
              meter_phase = PH_HIGH;
            end
            pending_verdicts.push_back(res);
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] result mismatch: %s", $time, what);
  endtask

  task automatic compare_beat(input out_t got);
    out_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch($sformatf("unexpected beat %h", got));
    end else begin
      want = pending_verdicts.pop_front();
      if (got.setting !== want.setting)
        report_mismatch($sformatf("setting %0d, want %0d", got.setting, want.setting));
      if (got.period_index !== want.period_index)
        report_mismatch($sformatf("period_index %0d, want %0d",
                                  got.period_index, want.period_index));
      if (got.period_ticks !== want.period_ticks)
        report_mismatch($sformatf("period_ticks %0d, want %0d (index %0d)",
                                  got.period_ticks, want.period_ticks, want.period_index));
      if (got.high_ticks !== want.high_ticks)
        report_mismatch($sformatf("high_ticks %0d, want %0d (index %0d)",
                                  got.high_ticks, want.high_ticks, want.period_index));
      if (got.verdict !== want.verdict)
        report_mismatch($sformatf("verdict %0d, want %0d (index %0d)",
                                  got.verdict, want.verdict, want.period_index));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound[REG_PERIOD_HIGH_A] = {1'b0, PERIOD_HIGH_A_RST};
      bound[REG_PERIOD_LOW_A]  = {1'b0, PERIOD_LOW_A_RST};
      bound[REG_PERIOD_HIGH_B] = {1'b0, PERIOD_HIGH_B_RST};
      bound[REG_PERIOD_LOW_B]  = {1'b0, PERIOD_LOW_B_RST};
      bound[REG_DUTY_HIGH_A]   = DUTY_HIGH_A_RST;
      bound[REG_DUTY_LOW_A]    = DUTY_LOW_A_RST;
      bound[REG_DUTY_HIGH_B]   = DUTY_HIGH_B_RST;
      bound[REG_DUTY_LOW_B]    = DUTY_LOW_B_RST;
      meter_phase   = PH_IDLE;
      meter_setting = 1'b0;
      period_num    = '0;
      last_level    = 1'b1;
      high_run      = '0;
      low_run       = '0;
      pending_verdicts.delete();
      mismatches    = 0;
    end else begin
      if (cfg_we_i) begin
        // period bounds keep only their low 16 bits
        if (cfg_idx_e'(cfg_idx_i) <= REG_PERIOD_LOW_B)
          bound[cfg_idx_i] = {1'b0, cfg_data_i[PBOUND_W-1:0]};
        else
          bound[cfg_idx_i] = cfg_data_i;
      end
      if (in_mon.valid && in_mon.ready) advance_meter(in_mon.data);
      if (out_mon.valid && out_mon.ready) compare_beat(out_mon.data);
    end
    fail_count_o <= mismatches;
    pending_o    <= pending_verdicts.size();
  end

endmodule

`default_nettype wire

### test/tb_pulse_period_duty_checker_unit.sv
// Testbench top for the pulse period and duty checker: drives start and tick beats,
// the bound registers and the result back-pressure, and prints the verdict.
// Depends on ppdc_pkg, ppdc_if, the block and ppdc_verdict_tracker.
`default_nettype none

module tb_pulse_period_duty_checker_unit;
  import ppdc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;   // cycles with no beat on either side
  localparam int unsigned HOLD_CYCLES = 400;    // long receiver hold-off
  localparam int unsigned DRAIN_WAIT  = 4;      // settle time after the pending results drain

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_sent;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_req;
  int unsigned hold_ack;
  int unsigned quiet_cycles;

  ppdc_in_if  in_bus ();
  ppdc_out_if out_bus ();

  pulse_period_duty_checker_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  ppdc_verdict_tracker tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Result side: random stalls, plus one long hold-off on request so that the
  // output register fills and the block has to stall its input.
  initial begin : result_sink
    int unsigned held;
    held = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        out_bus.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_ack = hold_req;
          held     = 0;
        end
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one beat after a random gap and hold it until the block takes it.
  task automatic send_beat(input logic beat_kind, input logic pin_level);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= '{kind: beat_kind, level: pin_level};
    do @(posedge clk_i); while (!in_bus.ready);
    beats_sent++;
  endtask

  task automatic send_pulse(input int unsigned hi_n, input int unsigned lo_n);
    repeat (hi_n) send_beat(KIND_TICK, 1'b1);
    repeat (lo_n) send_beat(KIND_TICK, 1'b0);
  endtask

  function automatic int unsigned wobble(input int unsigned base, input int unsigned jit);
    int signed v;
    v = int'(base) + int'($urandom_range(2 * jit)) - int'(jit);
    return (v < 1) ? 1 : v;
  endfunction

  // One check: start, a low lead-in, five pulses shaped for setting 0 (four
  // periods plus the closing edge), then five for setting 1. Now and then a
  // start lands in the middle and breaks the sequence.
  task automatic run_check(input int unsigned ha, input int unsigned la,
                           input int unsigned hb, input int unsigned lb,
                           input int unsigned jit);
    int unsigned n;
    send_beat(KIND_START, 1'($urandom_range(1)));
    repeat ($urandom_range(2, 1)) send_beat(KIND_TICK, 1'b0);
    for (n = 0; n < 10; n++) begin
      if ($urandom_range(39) == 0) begin
        send_beat(KIND_START, 1'($urandom_range(1)));
      end
      if (n < 5) begin
        send_pulse(wobble(ha, jit), wobble(la, jit));
      end else begin
        send_pulse(wobble(hb, jit), wobble(lb, jit));
      end
    end
  endtask

  task automatic random_phase(input int unsigned a_max, input int unsigned b_max,
                              input int unsigned jit, input int unsigned count);
    int unsigned stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        // stray beats of any kind
        repeat ($urandom_range(6, 1)) send_beat(1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        run_check($urandom_range(a_max, 1), $urandom_range(a_max, 1),
                  $urandom_range(b_max, 1), $urandom_range(b_max, 1), jit);
      end
    end
  endtask

  // Drop valid, wait for every queued result, then let in-flight beats settle.
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Load all eight bounds while the block is idle; period bounds get a random
  // spare top bit, which the block must drop.
  task automatic load_bounds(input logic [PBOUND_W-1:0] pha, input logic [PBOUND_W-1:0] pla,
                             input logic [PBOUND_W-1:0] phb, input logic [PBOUND_W-1:0] plb,
                             input logic [DBOUND_W-1:0] dha, input logic [DBOUND_W-1:0] dla,
                             input logic [DBOUND_W-1:0] dhb, input logic [DBOUND_W-1:0] dlb);
    settle();
    put_reg(REG_PERIOD_HIGH_A, {1'($urandom_range(1)), pha});
    put_reg(REG_PERIOD_LOW_A,  {1'($urandom_range(1)), pla});
    put_reg(REG_PERIOD_HIGH_B, {1'($urandom_range(1)), phb});
    put_reg(REG_PERIOD_LOW_B,  {1'($urandom_range(1)), plb});
    put_reg(REG_DUTY_HIGH_A, dha);
    put_reg(REG_DUTY_LOW_A,  dla);
    put_reg(REG_DUTY_HIGH_B, dhb);
    put_reg(REG_DUTY_LOW_B,  dlb);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_PERIOD_HIGH_A;
    cfg_data_i    = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    beats_sent    = 0;
    hold_req      = 0;
    snd_idle_pct  = 13;
    rcv_idle_pct  = 81;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset bounds. Ticks while idle are ignored; the edge wait needs a low
    // tick first; starts abort a check waiting for its edge and one counting.
    send_beat(KIND_TICK, 1'b0);
    send_beat(KIND_TICK, 1'b1);
    send_beat(KIND_START, 1'b1);
    send_beat(KIND_TICK, 1'b1);
    send_beat(KIND_TICK, 1'b0);
    send_beat(KIND_START, 1'b0);
    send_beat(KIND_TICK, 1'b0);
    send_beat(KIND_TICK, 1'b1);
    send_beat(KIND_START, 1'b0);
    // one check shaped for the reset bounds
    run_check(62, 18, 14, 6, 1);

    // Loose bounds; the shortest possible periods pass both settings.
    load_bounds(14, 1, 10, 1, 60000, 20000, 50000, 15000);
    run_check(1, 1, 1, 1, 0);
    random_phase(7, 5, 1, 200);

    // Swap the idle pattern: sender sparse, receiver mostly ready.
    snd_idle_pct = 81;
    rcv_idle_pct = 13;
    // Tight bounds: only period 8 at half duty, or period 6 at two thirds, pass.
    load_bounds(9, 7, 7, 5, 32769, 32767, 43691, 43690);
    random_phase(5, 4, 0, 150);
    // A duty of exactly one half sits on the bound and fails both ways.
    load_bounds(16'hFFFF, 0, 16'hFFFF, 0, 32768, 0, 17'h1FFFF, 32768);
    random_phase(4, 4, 1, 125);

    // No idling from here on.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // All bounds zero: every period fails.
    load_bounds(0, 0, 0, 0, 0, 0, 0, 0);
    random_phase(3, 3, 0, 75);
    // All bounds at maximum: the lower period bound fails everything.
    load_bounds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    random_phase(3, 3, 0, 75);
    // Wide open bounds: checks pass unless a count saturates. Hold the
    // result side off for a long stretch while beats keep coming.
    load_bounds(16'hFFFF, 0, 16'hFFFF, 0, 17'h1FFFF, 0, 17'h1FFFF, 0);
    hold_req++;
    random_phase(6, 6, 1, 125);

    settle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
